FILE: hw/rtl/xtms_pkg.sv
// Shared types and constants for the xoroshiro threshold mismatch scorer.
package xtms_pkg;

  // Longest run the score is sized for, and the saturation cap of the score
  localparam int unsigned MAX_OBS    = 65536;
  localparam int unsigned SCORE_FULL = 63 * MAX_OBS;
  localparam int unsigned SCORE_W    = 22;
  localparam logic [SCORE_W-1:0] SCORE_CAP =
    (SCORE_FULL < 32'h003F_FFFF) ? SCORE_W'(SCORE_FULL) : {SCORE_W{1'b1}};

  // Field widths
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned THR_W    = 25;
  localparam int unsigned STEP_W   = 2;
  localparam int unsigned WEIGHT_W = 6;
  localparam int unsigned INDEX_W  = 8;

  // Queue between classifier and accumulator
  localparam int unsigned Q_DEPTH  = 4;
  localparam int unsigned Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W  = $clog2(Q_DEPTH + 1);

  // Configuration register indexes
  localparam logic [INDEX_W-1:0] REG_CAND_LOW    = 8'd0;
  localparam logic [INDEX_W-1:0] REG_CAND_HIGH   = 8'd1;
  localparam logic [INDEX_W-1:0] REG_STEP_COUNT  = 8'd2;
  localparam logic [INDEX_W-1:0] REG_RARE_WEIGHT = 8'd3;

  // Configuration as seen by the classifier
  typedef struct packed {
    logic [KEY_W-1:0]    cand_low;
    logic [KEY_W-1:0]    cand_high;
    logic [STEP_W-1:0]   step_count;
    logic [WEIGHT_W-1:0] rare_weight;
  } xtms_cfg_t;

  // One classified word: score increment and end-of-run mark
  typedef struct packed {
    logic [WEIGHT_W-1:0] add;
    logic                last;
  } xtms_item_t;

  // Occupancy of the classifier stages
  typedef struct packed {
    logic stage_a;
    logic stage_b;
  } xtms_busy_t;

endpackage

FILE: hw/rtl/xtms_front.sv
// Classifier: state steps, ++ output, threshold compare and mismatch weight.
module xtms_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [xtms_pkg::KEY_W-1:0]  in_key,
  input  logic [xtms_pkg::THR_W-1:0]  in_thr,
  input  logic                        in_expected,
  input  logic                        in_last,
  input  xtms_pkg::xtms_cfg_t         cfg,
  output logic                        push,
  output xtms_pkg::xtms_item_t        push_item,
  output xtms_pkg::xtms_busy_t        busy
);
  import xtms_pkg::*;

  // One xoroshiro128 state step, returns {a, b}
  function automatic logic [2*KEY_W-1:0] state_step(logic [KEY_W-1:0] a,
                                                    logic [KEY_W-1:0] b);
    logic [KEY_W-1:0] mix;
    logic [KEY_W-1:0] na;
    logic [KEY_W-1:0] nb;
    mix = a ^ b;
    na  = {a[14:0], a[63:15]} ^ mix ^ (mix << 21);
    nb  = {mix[35:0], mix[63:36]};
    return {na, nb};
  endfunction

  logic [2*KEY_W-1:0] step1;
  logic [2*KEY_W-1:0] step2;
  logic [KEY_W-1:0]   st_a;
  logic [KEY_W-1:0]   st_b;
  logic [KEY_W-1:0]   lo_c;
  logic [KEY_W-1:0]   hi_c;

  // Stage A registers
  logic               a_valid;
  logic [KEY_W-1:0]   a_lo;
  logic [KEY_W-1:0]   a_sum;
  logic [THR_W-1:0]   a_thr;
  logic               a_expected;
  logic               a_last;

  // Stage B logic and registers
  logic [KEY_W-1:0]    mixed;
  logic                predicted;
  logic [WEIGHT_W-1:0] add_c;
  logic                b_valid;
  xtms_item_t          b_item;

  // Unrolled state steps from (key, 0), selected by step count
  always_comb begin
    step1 = state_step(in_key, '0);
    step2 = state_step(step1[2*KEY_W-1:KEY_W], step1[KEY_W-1:0]);
    case (cfg.step_count)
      2'd0: begin
        st_a = in_key;
        st_b = '0;
      end
      2'd1: begin
        st_a = step1[2*KEY_W-1:KEY_W];
        st_b = step1[KEY_W-1:0];
      end
      default: begin
        st_a = step2[2*KEY_W-1:KEY_W];
        st_b = step2[KEY_W-1:0];
      end
    endcase
    lo_c = cfg.cand_low ^ st_a;
    hi_c = cfg.cand_high ^ st_b;
  end

  // Stage A: hold low half and the first sum
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
    a_lo       <= lo_c;
    a_sum      <= lo_c + hi_c;
    a_thr      <= in_thr;
    a_expected <= in_expected;
    a_last     <= in_last;
  end

  // Rotate, second add, compare top 24 bits below the threshold
  always_comb begin
    mixed     = {a_sum[46:0], a_sum[63:47]} + a_lo;
    predicted = {1'b0, mixed[63:40]} < a_thr;
    if (predicted == a_expected) begin
      add_c = '0;
    end else if (a_expected) begin
      add_c = cfg.rare_weight;
    end else begin
      add_c = WEIGHT_W'(1);
    end
  end

  // Stage B: hold the classified word for the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
    b_item.add  <= add_c;
    b_item.last <= a_last;
  end

  assign push         = b_valid;
  assign push_item    = b_item;
  assign busy.stage_a = a_valid;
  assign busy.stage_b = b_valid;

endmodule

FILE: hw/rtl/xtms_queue.sv
// Short queue that decouples the classifier from the accumulator.
module xtms_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  xtms_pkg::xtms_item_t          push_item,
  input  logic                          pop,
  output logic                          q_valid,
  output xtms_pkg::xtms_item_t          q_item,
  output logic [xtms_pkg::Q_CNT_W-1:0]  count
);
  import xtms_pkg::*;

  xtms_item_t         mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;

  // Write the incoming word
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + Q_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

  assign q_valid = (count != '0);
  assign q_item  = mem[rd_ptr];

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count above depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> (count < Q_CNT_W'(Q_DEPTH)))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("pop from empty queue");
`endif

endmodule

FILE: hw/rtl/xtms_back.sv
// Accumulator: saturating weighted score and registered result word.
module xtms_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  xtms_pkg::xtms_item_t          q_item,
  output logic                          pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [xtms_pkg::SCORE_W-1:0]  score
);
  import xtms_pkg::*;

  logic [SCORE_W-1:0] acc;
  logic [SCORE_W:0]   acc_sum;
  logic [SCORE_W-1:0] acc_sat;

  // Take a word only when the result register is free or draining
  assign pop = q_valid && (!m_tvalid || m_tready);

  // Add and clamp at the cap
  always_comb begin
    acc_sum = {1'b0, acc} + (SCORE_W + 1)'(q_item.add);
    if (acc_sum > {1'b0, SCORE_CAP}) begin
      acc_sat = SCORE_CAP;
    end else begin
      acc_sat = acc_sum[SCORE_W-1:0];
    end
  end

  // Hold the running score, emit and clear it on the last word
  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (pop && q_item.last) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (pop) begin
        if (q_item.last) begin
          acc <= '0;
        end else begin
          acc <= acc_sat;
        end
      end
    end
    if (pop && q_item.last) begin
      score <= acc_sat;
    end
  end

`ifndef ASSERT_OFF
  a_acc_capped: assert property (@(posedge clk) disable iff (rst)
    acc <= SCORE_CAP)
    else $error("score above cap");
  a_result_capped: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (score <= SCORE_CAP))
    else $error("result above cap");
`endif

endmodule

FILE: hw/rtl/xoroshiro_threshold_mismatch_scorer.sv
// Top level of the xoroshiro threshold mismatch scorer.
// Scores one 128-bit candidate seed against a stream of observation words.
// Each word's key goes through 0, 1 or 2 xoroshiro128 state steps from
// (key, 0), is XORed into the candidate, and the top 24 bits of the ++ output
// are compared below the Q1.24 threshold; a mismatch against the expected bit
// adds 1, or the rare weight when the expected bit is 1. The saturating score
// comes out as one word after the word marked tlast, then clears. Sustained
// rate is one input word per clock: two classifier stages feed a four-entry
// queue that the accumulator drains one word per cycle, and s_tready drops
// only once four words are held between those stages and the queue (output
// back-pressure). A last word's score passes through stage A, stage B and the
// queue before it is registered onto m_tvalid. Configuration writes must only
// be made while no run is in flight.
module xoroshiro_threshold_mismatch_scorer (
  input  logic                          clk,
  input  logic                          rst,
  // s_tdata: obs_key[63:0], threshold_q24[88:64], expected_bit[89], zero pad
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [95:0]                   s_tdata,
  input  logic                          s_tlast,
  // m_tdata: total_score[21:0], zero pad
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [23:0]                   m_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [xtms_pkg::INDEX_W-1:0]  cfg_index,
  input  logic [63:0]                   cfg_data
);
  import xtms_pkg::*;

  xtms_cfg_t          cfg;
  logic               in_accept;
  logic               push;
  xtms_item_t         push_item;
  xtms_busy_t         busy;
  logic               pop;
  logic               q_valid;
  xtms_item_t         q_item;
  logic [Q_CNT_W-1:0] q_count;
  logic [Q_CNT_W-1:0] held;
  logic [SCORE_W-1:0] score;

  // Reserve queue room for every word in the classifier
  assign held      = q_count + Q_CNT_W'(busy.stage_a) + Q_CNT_W'(busy.stage_b);
  assign s_tready  = (held < Q_CNT_W'(Q_DEPTH));
  assign in_accept = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cand_low    <= '0;
      cfg.cand_high   <= '0;
      cfg.step_count  <= '0;
      cfg.rare_weight <= WEIGHT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CAND_LOW:    cfg.cand_low    <= cfg_data;
        REG_CAND_HIGH:   cfg.cand_high   <= cfg_data;
        REG_STEP_COUNT:  cfg.step_count  <= cfg_data[STEP_W-1:0];
        REG_RARE_WEIGHT: cfg.rare_weight <= cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  xtms_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_accept),
    .in_key      (s_tdata[63:0]),
    .in_thr      (s_tdata[88:64]),
    .in_expected (s_tdata[89]),
    .in_last     (s_tlast),
    .cfg         (cfg),
    .push        (push),
    .push_item   (push_item),
    .busy        (busy)
  );

  xtms_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .count     (q_count)
  );

  xtms_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .score    (score)
  );

  assign m_tdata = {2'b00, score};

`ifndef ASSERT_OFF
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    held <= Q_CNT_W'(Q_DEPTH))
    else $error("words in flight exceed queue room");
`endif

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the xoroshiro threshold mismatch scorer.
`timescale 1ns / 1ps

module testbench;
  import xtms_pkg::*;

  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 100;
  localparam int STEADY_ITEMS   = 150;

  // Writes to these indexes must leave every register untouched
  localparam logic [INDEX_W-1:0] REG_UNUSED_LOW = 8'd4;
  localparam logic [INDEX_W-1:0] REG_UNUSED_TOP = 8'hFF;

  localparam logic [THR_W-1:0] THR_ONE = 25'h100_0000;
  localparam logic [THR_W-1:0] THR_MAX = 25'h1FF_FFFF;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic [95:0]         s_tdata   = '0;
  logic                s_tlast   = 1'b0;
  logic                m_tready  = 1'b1;
  logic                cfg_valid = 1'b0;
  logic [INDEX_W-1:0]  cfg_index = '0;
  logic [63:0]         cfg_data  = '0;
  wire                 s_tready;
  wire                 m_tvalid;
  wire  [23:0]         m_tdata;
  wire                 cfg_ready;

  // Scoring state mirrored from the block's registers
  logic [KEY_W-1:0]    seed_low    = '0;
  logic [KEY_W-1:0]    seed_high   = '0;
  logic [STEP_W-1:0]   key_steps   = '0;
  logic [WEIGHT_W-1:0] rare_wt     = 6'd1;
  logic [22:0]         run_score   = '0;

  logic [SCORE_W-1:0]  expected_scores[$];

  bit idle_on = 1'b1;
  int errors;
  int words_sent;
  int runs_closed;
  int scores_checked;
  int reg_writes;
  int quiet_cycles;

  xoroshiro_threshold_mismatch_scorer dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
    return (x << r) | (x >> (64 - r));
  endfunction

  // Top 24 bits of the ++ output for one key under the current seed
  function automatic logic [23:0] seed_top(input logic [KEY_W-1:0] key);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] mix;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mixed;
    int          n;
    a = key;
    b = '0;
    n = (key_steps > 2'd2) ? 2 : int'(key_steps);
    for (int i = 0; i < n; i++) begin
      mix = a ^ b;
      a   = rotl64(a, 49) ^ mix ^ (mix << 21);
      b   = rotl64(mix, 28);
    end
    lo    = seed_low ^ a;
    hi    = seed_high ^ b;
    mixed = rotl64(lo + hi, 17) + lo;
    return mixed[63:40];
  endfunction

  // Fold one accepted word into the running score, queue the score on last
  function automatic void score_word(input logic [KEY_W-1:0] key, input logic [THR_W-1:0] thr,
                                     input logic exp_bit, input logic last);
    logic       predicted;
    logic [22:0] sum;
    predicted = ({1'b0, seed_top(key)} < thr);
    if (predicted != exp_bit) begin
      sum = run_score + (exp_bit ? {17'b0, rare_wt} : 23'd1);
      run_score = (sum > {1'b0, SCORE_CAP}) ? {1'b0, SCORE_CAP} : sum;
    end
    if (last) begin
      expected_scores.insert(expected_scores.size(), run_score[SCORE_W-1:0]);
      run_score = '0;
      runs_closed++;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    $display("mismatch @%0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  // Send one observation word; valid stays high after acceptance
  task automatic send_obs(input logic [KEY_W-1:0] key, input logic [THR_W-1:0] thr,
                          input logic exp_bit, input logic last);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, exp_bit, thr, key};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    score_word(key, thr, exp_bit, last);
    words_sent++;
  endtask

  // Hold off input until every queued score has come back
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_scores.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [INDEX_W-1:0] index, input logic [63:0] value);
    s_tvalid  <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (index)
      REG_CAND_LOW:    seed_low  = value;
      REG_CAND_HIGH:   seed_high = value;
      REG_STEP_COUNT:  key_steps = value[STEP_W-1:0];
      REG_RARE_WEIGHT: rare_wt   = value[WEIGHT_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Half the time place the threshold right around the computed value
  function automatic logic [THR_W-1:0] pick_threshold(input logic [KEY_W-1:0] key);
    int top;
    case ($urandom_range(0, 7))
      0, 1: return THR_W'($urandom);
      2:    return '0;
      3:    return ($urandom_range(0, 1) == 0) ? THR_ONE : THR_MAX;
      default: begin
        top = int'(seed_top(key)) + $urandom_range(0, 2) - 1;
        return (top < 0) ? '0 : THR_W'(top);
      end
    endcase
  endfunction

  // Random-content run of n words, closed with last when asked
  task automatic send_run(input int n, input bit close);
    logic [KEY_W-1:0] key;
    for (int i = 0; i < n; i++) begin
      key = rand64();
      send_obs(key, pick_threshold(key), 1'($urandom), close && (i == n - 1));
    end
  endtask

  // Default registers straight out of reset
  task automatic test_reset_defaults();
    send_obs('0, '0, 1'b0, 1'b1);
    send_obs('1, THR_ONE, 1'b0, 1'b0);
    send_obs('0, THR_MAX, 1'b1, 1'b0);
    send_obs(64'h0123_4567_89AB_CDEF, '0, 1'b1, 1'b1);
  endtask

  // Masked writes, ignored indexes, zero weight and step counts 3, 1 and 2
  task automatic test_register_writes();
    wait_idle();
    set_reg(REG_CAND_LOW, '1);
    set_reg(REG_CAND_HIGH, 64'h8000_0000_0000_0001);
    set_reg(REG_STEP_COUNT, '1);
    set_reg(REG_RARE_WEIGHT, 64'hFFFF_FFFF_FFFF_FFC0);
    set_reg(REG_UNUSED_LOW, '1);
    set_reg(REG_UNUSED_TOP, 64'h5A5A_5A5A_5A5A_5A5A);
    send_obs('0, '0, 1'b1, 1'b0);
    send_obs('1, '0, 1'b1, 1'b0);
    send_obs(64'h8000_0000_0000_0000, THR_ONE, 1'b0, 1'b0);
    send_obs(64'h1, THR_MAX, 1'b1, 1'b1);
    wait_idle();
    set_reg(REG_CAND_LOW, '0);
    set_reg(REG_CAND_HIGH, '0);
    set_reg(REG_STEP_COUNT, 64'd1);
    set_reg(REG_RARE_WEIGHT, 64'd63);
    send_obs('0, pick_threshold('0), 1'b1, 1'b0);
    send_obs('1, {1'b0, seed_top('1)}, 1'b1, 1'b0);
    send_obs(64'h8000_0000_0000_0000, THR_ONE, 1'b0, 1'b1);
    wait_idle();
    set_reg(REG_STEP_COUNT, 64'd2);
    set_reg(REG_CAND_HIGH, '1);
    send_obs('1, {1'b0, seed_top('1)} + 25'd1, 1'b0, 1'b0);
    send_obs(64'hDEAD_BEEF_0000_FFFF, '0, 1'b1, 1'b0);
    send_obs('0, THR_MAX, 1'b0, 1'b1);
  endtask

  // Random configurations with well-formed runs and some unterminated ones
  task automatic test_random_runs();
    int left;
    int n;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      idle_on = (p != 3);
      case ($urandom_range(0, 2))
        0:       set_reg(REG_CAND_LOW, '0);
        1:       set_reg(REG_CAND_LOW, '1);
        default: set_reg(REG_CAND_LOW, rand64());
      endcase
      set_reg(REG_CAND_HIGH, (p == 1) ? '1 : rand64());
      set_reg(REG_STEP_COUNT, {$urandom, 30'($urandom), p[1:0]});
      case (p % 4)
        0:       set_reg(REG_RARE_WEIGHT, 64'd1);
        1:       set_reg(REG_RARE_WEIGHT, 64'd63);
        2:       set_reg(REG_RARE_WEIGHT, {58'($urandom), 6'd0});
        default: set_reg(REG_RARE_WEIGHT, rand64());
      endcase
      if ($urandom_range(0, 3) == 0) set_reg(INDEX_W'($urandom_range(4, 255)), rand64());
      left = PHASE_ITEMS;
      while (left > 0) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 24);
        if (n > left) n = left;
        left -= n;
        // A run left open merges into the next one
        send_run(n, (left == 0) || ($urandom_range(0, 9) != 0));
        if ($urandom_range(0, 7) == 0) wait_idle();
      end
    end
  endtask

  // Back-to-back traffic with no idling on either side
  task automatic test_steady_stream();
    wait_idle();
    idle_on = 1'b0;
    set_reg(REG_CAND_LOW, rand64());
    set_reg(REG_CAND_HIGH, rand64());
    set_reg(REG_STEP_COUNT, 64'd2);
    set_reg(REG_RARE_WEIGHT, 64'($urandom_range(1, 63)));
    for (int i = 0; i < STEADY_ITEMS / 10; i++) send_run(10, 1'b1);
  endtask

  // Output side stalls in random bursts
  int stall_left;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      stall_left = $urandom_range(0, 6);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Compare each score word with the oldest queued score
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_scores.size() == 0) begin
        report_mismatch("unexpected score word", m_tdata, '0);
      end else begin
        if (m_tdata[SCORE_W-1:0] != expected_scores[0])
          report_mismatch("total_score", {2'b0, m_tdata[SCORE_W-1:0]},
                          {2'b0, expected_scores[0]});
        if (m_tdata[23:SCORE_W] != '0)
          report_mismatch("m_tdata pad", {22'b0, m_tdata[23:SCORE_W]}, '0);
        void'(expected_scores.pop_front());
        scores_checked++;
      end
    end
  end

  // End the run when no word moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_register_writes();
    test_random_runs();
    test_steady_stream();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_scores.size() != 0)
      report_mismatch("scores never delivered", 24'(expected_scores.size()), '0);
    $display("covered %0d observation words in %0d scored runs, %0d register writes",
             words_sent, runs_closed, reg_writes);
    $display("checked %0d score words, %0d mismatches", scores_checked, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
